[hdl/c123pm_pkg.sv]
// shared types, constants and helper functions of the predict and map unit
`default_nettype none

package c123pm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int DIFF_W   = 20;
  localparam int WEIGHT_W = 22;
  localparam int PROD_W   = DIFF_W + WEIGHT_W;
  localparam int ACC_W    = 64;
  localparam int LSUM_W   = 18;
  localparam int CENT_W   = 20;
  localparam int QUO_W    = 60;
  localparam int SAMP_W   = 16;
  localparam int SPRED_W  = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [4:0] WRES_MIN = 5'd4;
  localparam logic [4:0] WRES_MAX = 5'd19;
  localparam logic [6:0] RSIZE_MIN = 7'd32;
  localparam logic [6:0] RSIZE_MAX = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_MIN        = 3'd0,
    REG_SAMPLE_MAX        = 3'd1,
    REG_SAMPLE_MID        = 3'd2,
    REG_WEIGHT_RESOLUTION = 3'd3,
    REG_REGISTER_SIZE     = 3'd4,
    REG_PRECEDING_BANDS   = 3'd5
  } c123pm_reg_t;

  typedef struct packed {
    logic valid;
    logic fin;
  } c123pm_ctl_t;

  typedef struct packed {
    logic              use_prev;
    logic              first;
    logic [SAMP_W-1:0] smp;
    logic [SAMP_W-1:0] prev;
  } c123pm_side_t;

  function automatic logic [4:0] clamp_wres(input logic [4:0] v);
    logic [4:0] r;
    if (v < WRES_MIN) begin
      r = WRES_MIN;
    end else if (v > WRES_MAX) begin
      r = WRES_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [6:0] clamp_rsize(input logic [6:0] v);
    logic [6:0] r;
    if (v < RSIZE_MIN) begin
      r = RSIZE_MIN;
    end else if (v > RSIZE_MAX) begin
      r = RSIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/ccsds123_predict_and_map_unit.sv]
// top level of the prediction and residual mapping unit
//
// input channel: a transaction is taken at a rising edge with start high and
// busy low; busy stays low, so one transaction can be taken every cycle
// kind 0 carries a difference and weight whose product is added into a
// 64-bit accumulator; kind 1 carries the finish fields and yields one result
// result channel: result_valid is high for one cycle with mapped_residual
// and scaled_prediction; the receiver cannot stall it
// term transactions give no result; the result of a finish transaction
// passes through every stage of the pipeline named below
// throughput: one transaction per cycle, set by the six-stage pipeline of
// input register, multiplier, accumulator, wrap and shift, offset and clip,
// residual map
// configuration: cfg_ready is always high, writes take effect next cycle;
// the user must make them only while no transaction is in flight, the block does not enforce it
// reset: the pipeline empties, the accumulator clears and the configuration
// registers return to their defaults
`default_nettype none

module ccsds123_predict_and_map_unit import c123pm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic signed [DIFF_W-1:0]   diff_value,
  input  logic signed [WEIGHT_W-1:0] weight_value,
  input  logic [LSUM_W-1:0]          local_sum,
  input  logic [SAMP_W-1:0]          sample,
  input  logic [SAMP_W-1:0]          prev_band_sample,
  input  logic [SAMP_W-1:0]          band_index,
  input  logic                       first_in_band,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       result_valid,
  output logic [SAMP_W-1:0]          mapped_residual,
  output logic [SPRED_W-1:0]         scaled_prediction
);

  localparam logic [SAMP_W:0]   SMASK_W = (17'd1 << SAMPLE_BITS) - 17'd1;
  localparam logic [SAMP_W-1:0] SMASK   = SMASK_W[SAMP_W-1:0];

  logic [SAMP_W-1:0] sample_min;
  logic [SAMP_W-1:0] sample_max;
  logic [SAMP_W-1:0] sample_mid;
  logic [4:0]        weight_resolution;
  logic [6:0]        register_size;
  logic [3:0]        preceding_bands;

  logic [SAMP_W-1:0] lo;
  logic [SAMP_W-1:0] hi;
  logic [SAMP_W-1:0] mid;
  logic [4:0]        wres;
  logic [6:0]        rsize;

  logic                       accept;
  c123pm_ctl_t                ctl1;
  logic signed [DIFF_W-1:0]   diff1;
  logic signed [WEIGHT_W-1:0] weight1;
  logic [LSUM_W-1:0]          lsum1;
  c123pm_side_t               side1;

  c123pm_ctl_t        ctl3;
  logic [ACC_W-1:0]   sum3;
  c123pm_side_t       side3;
  c123pm_ctl_t        ctl5;
  logic [SPRED_W-1:0] spred5;
  c123pm_side_t       side5;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_min        <= 16'd0;
      sample_max        <= 16'd65535;
      sample_mid        <= 16'd32768;
      weight_resolution <= 5'd13;
      register_size     <= 7'd64;
      preceding_bands   <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLE_MIN:        sample_min        <= cfg_data;
        REG_SAMPLE_MAX:        sample_max        <= cfg_data;
        REG_SAMPLE_MID:        sample_mid        <= cfg_data;
        REG_WEIGHT_RESOLUTION: weight_resolution <= cfg_data[4:0];
        REG_REGISTER_SIZE:     register_size     <= cfg_data[6:0];
        REG_PRECEDING_BANDS:   preceding_bands   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign lo    = sample_min & SMASK;
  assign hi    = sample_max & SMASK;
  assign mid   = sample_mid & SMASK;
  assign wres  = clamp_wres(weight_resolution);
  assign rsize = clamp_rsize(register_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1.valid <= accept;
      ctl1.fin   <= kind;
    end
    diff1          <= diff_value;
    weight1        <= weight_value;
    lsum1          <= local_sum;
    side1.use_prev <= (band_index != '0) && (preceding_bands != '0);
    side1.first    <= first_in_band;
    side1.smp      <= sample & SMASK;
    side1.prev     <= prev_band_sample & SMASK;
  end

  c123pm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl1),
    .in_diff   (diff1),
    .in_weight (weight1),
    .in_lsum   (lsum1),
    .in_side   (side1),
    .mid       (mid),
    .wres      (wres),
    .out_ctl   (ctl3),
    .out_sum   (sum3),
    .out_side  (side3)
  );

  c123pm_predict u_predict (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl3),
    .in_sum    (sum3),
    .in_side   (side3),
    .lo        (lo),
    .hi        (hi),
    .mid       (mid),
    .wres      (wres),
    .rsize     (rsize),
    .out_ctl   (ctl5),
    .out_spred (spred5),
    .out_side  (side5)
  );

  c123pm_map #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_map (
    .clk               (clk),
    .rst               (rst),
    .in_ctl            (ctl5),
    .in_spred          (spred5),
    .in_side           (side5),
    .lo                (lo),
    .hi                (hi),
    .result_valid      (result_valid),
    .mapped_residual   (mapped_residual),
    .scaled_prediction (scaled_prediction)
  );

endmodule

`default_nettype wire

[hdl/c123pm_mac.sv]
// multiply-accumulate of term transactions and centred local sum addition
`default_nettype none

module c123pm_mac import c123pm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  c123pm_ctl_t                in_ctl,
  input  logic signed [DIFF_W-1:0]   in_diff,
  input  logic signed [WEIGHT_W-1:0] in_weight,
  input  logic [LSUM_W-1:0]          in_lsum,
  input  c123pm_side_t               in_side,
  input  logic [SAMP_W-1:0]          mid,
  input  logic [4:0]                 wres,
  output c123pm_ctl_t                out_ctl,
  output logic [ACC_W-1:0]           out_sum,
  output c123pm_side_t               out_side
);

  c123pm_ctl_t              ctl2;
  logic signed [PROD_W-1:0] prod;
  logic signed [CENT_W-1:0] cent;
  c123pm_side_t             side2;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         cent_ext;
  logic [ACC_W-1:0]         cent_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else begin
      ctl2 <= in_ctl;
    end
    prod  <= in_diff * in_weight;
    cent  <= $signed({2'b00, in_lsum}) - $signed({2'b00, mid, 2'b00});
    side2 <= in_side;
  end

  assign cent_ext   = {{(ACC_W-CENT_W){cent[CENT_W-1]}}, cent};
  assign cent_shift = cent_ext << wres;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= ctl2.valid && ctl2.fin;
      out_ctl.fin   <= 1'b1;
      if (ctl2.valid && ctl2.fin) begin
        acc <= '0;
      end else if (ctl2.valid) begin
        acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
    end
    out_sum  <= acc + cent_shift;
    out_side <= side2;
  end

endmodule

`default_nettype wire

[hdl/c123pm_predict.sv]
// register wrap, weight scaling, offset and clipping of the scaled prediction
`default_nettype none

module c123pm_predict import c123pm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  c123pm_ctl_t        in_ctl,
  input  logic [ACC_W-1:0]   in_sum,
  input  c123pm_side_t       in_side,
  input  logic [SAMP_W-1:0]  lo,
  input  logic [SAMP_W-1:0]  hi,
  input  logic [SAMP_W-1:0]  mid,
  input  logic [4:0]         wres,
  input  logic [6:0]         rsize,
  output c123pm_ctl_t        out_ctl,
  output logic [SPRED_W-1:0] out_spred,
  output c123pm_side_t       out_side
);

  logic [ACC_W-1:0]          wmask;
  logic                      wsign;
  logic [ACC_W-1:0]          wrapped;
  logic [ACC_W-1:0]          shifted;
  logic [4:0]                wshift;
  c123pm_ctl_t               ctl4;
  logic signed [QUO_W-1:0]   quo;
  c123pm_side_t              side4;
  logic signed [QUO_W:0]     total;
  logic signed [QUO_W:0]     lim_lo;
  logic signed [QUO_W:0]     lim_hi;
  logic [SPRED_W-1:0]        spred_next;

  assign wmask   = ~({ACC_W{1'b1}} << rsize);
  assign wsign   = in_sum[6'(rsize - 7'd1)];
  assign wrapped = wsign ? (in_sum | ~wmask) : (in_sum & wmask);
  assign wshift  = wres + 5'd1;
  assign shifted = $unsigned($signed(wrapped) >>> wshift);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
    end else begin
      ctl4 <= in_ctl;
    end
    quo   <= $signed(shifted[QUO_W-1:0]);
    side4 <= in_side;
  end

  assign total  = {quo[QUO_W-1], quo} + $signed({{(QUO_W-SPRED_W+1){1'b0}}, mid, 1'b1});
  assign lim_lo = $signed({{(QUO_W-SPRED_W+1){1'b0}}, lo, 1'b0});
  assign lim_hi = $signed({{(QUO_W-SPRED_W+1){1'b0}}, hi, 1'b1});

  always_comb begin
    priority if (side4.first) begin
      spred_next = side4.use_prev ? {side4.prev, 1'b0} : {mid, 1'b0};
    end else if (total < lim_lo) begin
      spred_next = {lo, 1'b0};
    end else if (total > lim_hi) begin
      spred_next = {hi, 1'b1};
    end else begin
      spred_next = total[SPRED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl4;
    end
    out_spred <= spred_next;
    out_side  <= side4;
  end

endmodule

`default_nettype wire

[hdl/c123pm_map.sv]
// residual mapping and result register
`default_nettype none

module c123pm_map import c123pm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  c123pm_ctl_t        in_ctl,
  input  logic [SPRED_W-1:0] in_spred,
  input  c123pm_side_t       in_side,
  input  logic [SAMP_W-1:0]  lo,
  input  logic [SAMP_W-1:0]  hi,
  output logic               result_valid,
  output logic [SAMP_W-1:0]  mapped_residual,
  output logic [SPRED_W-1:0] scaled_prediction
);

  localparam logic [SAMP_W:0]   SMASK_W = (17'd1 << SAMPLE_BITS) - 17'd1;
  localparam logic [SAMP_W-1:0] SMASK   = SMASK_W[SAMP_W-1:0];

  logic [SAMP_W-1:0]   pred;
  logic signed [17:0]  delta;
  logic signed [17:0]  mag;
  logic signed [17:0]  t1;
  logic signed [17:0]  t2;
  logic signed [17:0]  theta;
  logic                even;
  logic signed [19:0]  mval;
  logic [SAMP_W-1:0]   mres_next;

  assign pred  = in_spred[SPRED_W-1:1];
  assign even  = ~in_spred[0];
  assign delta = $signed({2'b00, in_side.smp}) - $signed({2'b00, pred});
  assign mag   = delta[17] ? -delta : delta;
  assign t1    = $signed({2'b00, pred}) - $signed({2'b00, lo});
  assign t2    = $signed({2'b00, hi}) - $signed({2'b00, pred});
  assign theta = (t1 > t2) ? t2 : t1;

  always_comb begin
    priority if (mag > theta) begin
      mval = {{2{mag[17]}}, mag} + {{2{theta[17]}}, theta};
    end else if ((even && !delta[17]) || (!even && (delta[17] || delta == 18'sd0))) begin
      mval = {mag[17], mag, 1'b0};
    end else begin
      mval = {mag[17], mag, 1'b0} - 20'sd1;
    end
    priority if (mval < 20'sd0) begin
      mres_next = '0;
    end else if (mval > $signed({4'b0000, SMASK})) begin
      mres_next = SMASK;
    end else begin
      mres_next = mval[SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= in_ctl.valid;
    end
    mapped_residual   <= mres_next;
    scaled_prediction <= in_spred;
  end

endmodule

`default_nettype wire

[hdl/c123pm_checker.sv]
// port level checks of the predict and map unit and their binding
`default_nettype none

module c123pm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic result_valid
);

  logic fin_acc;
  logic term_acc;

  assign fin_acc  = start && !busy && kind;
  assign term_acc = start && !busy && !kind;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

  a_fin_gives_result: assert property (@(posedge clk) disable iff (rst)
    fin_acc |-> ##6 result_valid)
    else $error("finish transaction gave no result");

  a_term_no_result: assert property (@(posedge clk) disable iff (rst)
    term_acc |-> ##6 !result_valid)
    else $error("term transaction gave a result");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(fin_acc, 6))
    else $error("result without a finish transaction");

endmodule

bind ccsds123_predict_and_map_unit c123pm_checker u_c123pm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .kind         (kind),
  .result_valid (result_valid)
);

`default_nettype wire
